/* hdl/ggc_pkg.sv */
package ggc_pkg;

  // Default size of the graph store and the limit set by the 6-bit vertex fields.
  localparam int MAX_VERTICES_DEF = 64;
  localparam int ROW_LIMIT        = 64;

  // Value of the vertex count register after reset.
  localparam logic [6:0] VCOUNT_RESET = 7'd64;

  // Operation codes of an input item.
  localparam logic [1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [1:0] OP_RUN      = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] vertex_a;
    logic [5:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic [5:0] vertex;
    logic [5:0] color;
    logic [6:0] colors_used;
    logic       edge_rejected;
    logic       last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic clear_graph;
    logic row_rd_a;
    logic row_rd_b;
    logic row_wr_a;
    logic row_wr_b;
    logic run_init;
    logic row_rd_v;
    logic scan_step;
    logic find_step;
    logic emit_start;
    logic emit_rd;
    logic out_load_edge;
    logic out_load_color;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       reject;
    logic       n_one;
    logic       u_last;
    logic       found;
    logic       v_last;
    logic       slot_free;
  } dp_status_t;

endpackage

/* hdl/ggc_ctrl.sv */
module ggc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ggc_pkg::dp_status_t sts,
  output ggc_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERDA,
    S_EWRA,
    S_ERDB,
    S_EWRB,
    S_EOUT,
    S_RINIT,
    S_ROW,
    S_SCAN,
    S_DRAIN,
    S_FIND,
    S_ESTART,
    S_ORD,
    S_OOUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.latch_in = 1'b1;
          priority if (sts.op == ggc_pkg::OP_ADD_EDGE) begin
            state_nxt = sts.reject ? S_EOUT : S_ERDA;
          end else if (sts.op == ggc_pkg::OP_RUN) begin
            state_nxt = S_RINIT;
          end else if (sts.op == ggc_pkg::OP_CLEAR) begin
            cmd.clear_graph = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ERDA: begin
        cmd.row_rd_a = 1'b1;
        state_nxt    = S_EWRA;
      end
      S_EWRA: begin
        cmd.row_wr_a = 1'b1;
        state_nxt    = S_ERDB;
      end
      S_ERDB: begin
        cmd.row_rd_b = 1'b1;
        state_nxt    = S_EWRB;
      end
      S_EWRB: begin
        cmd.row_wr_b = 1'b1;
        state_nxt    = S_EOUT;
      end
      S_EOUT: begin
        if (sts.slot_free) begin
          cmd.out_load_edge = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_RINIT: begin
        cmd.run_init = 1'b1;
        state_nxt    = sts.n_one ? S_ESTART : S_ROW;
      end
      S_ROW: begin
        cmd.row_rd_v = 1'b1;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.u_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIND;
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (sts.found) begin
          state_nxt = sts.v_last ? S_ESTART : S_ROW;
        end
      end
      S_ESTART: begin
        cmd.emit_start = 1'b1;
        state_nxt      = S_ORD;
      end
      S_ORD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_OOUT;
      end
      S_OOUT: begin
        if (sts.slot_free) begin
          cmd.out_load_color = 1'b1;
          state_nxt          = sts.v_last ? S_IDLE : S_ORD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/ggc_datapath.sv */
module ggc_datapath #(
  parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ggc_pkg::in_item_t   in_data,
  input  logic                cfg_valid,
  input  logic [6:0]          cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output ggc_pkg::out_item_t  out_data,
  input  ggc_pkg::ctrl_cmd_t  cmd,
  output ggc_pkg::dp_status_t sts
);

  localparam int VLIM = (MAX_VERTICES < ggc_pkg::ROW_LIMIT) ? MAX_VERTICES : ggc_pkg::ROW_LIMIT;
  localparam int VW   = $clog2(VLIM);
  localparam logic [6:0] VLIM7 = 7'(VLIM);

  // Adjacency rows, with one valid bit per row so that a clear only resets the valid bits.
  logic [VLIM-1:0] adj_mem [VLIM];
  logic [VLIM-1:0] adj_rd_r;
  logic            rd_vld_r;
  logic [VLIM-1:0] row_vld_r;

  // Colors assigned by the latest run.
  logic [VW-1:0]   col_mem [VLIM];
  logic [VW-1:0]   col_rd_r;

  logic [6:0]      vcount_r;
  logic [VW-1:0]   a_r;
  logic [VW-1:0]   b_r;
  logic            rej_r;
  logic [VW-1:0]   u_r;
  logic [VW-1:0]   v_r;
  logic [VW-1:0]   c_r;
  logic [VLIM-1:0] mask_r;
  logic            pend_r;
  logic [VW:0]     total_r;
  logic            out_valid_r;
  ggc_pkg::out_item_t out_q_r;

  logic [6:0]      n7;
  logic [VW-1:0]   nm1;
  logic [VLIM-1:0] row_w;
  logic            adj_re;
  logic [VW-1:0]   adj_raddr;
  logic            adj_we;
  logic [VW-1:0]   adj_waddr;
  logic [VLIM-1:0] adj_wdata;
  logic            col_re;
  logic [VW-1:0]   col_raddr;
  logic            col_we;
  logic [VW-1:0]   col_waddr;
  logic [VW-1:0]   col_wdata;
  logic            found;
  logic            v_last;
  logic [VW:0]     c_plus1;

  always_comb begin
    priority if (vcount_r == 7'd0) begin
      n7 = 7'd1;
    end else if (vcount_r > VLIM7) begin
      n7 = VLIM7;
    end else begin
      n7 = vcount_r;
    end
  end

  assign nm1     = VW'(n7 - 7'd1);
  assign row_w   = rd_vld_r ? adj_rd_r : '0;
  assign found   = !mask_r[c_r];
  assign v_last  = (v_r == nm1);
  assign c_plus1 = {1'b0, c_r} + (VW+1)'(1);

  assign sts.op        = in_data.operation;
  assign sts.reject    = ({1'b0, in_data.vertex_a} >= n7) || ({1'b0, in_data.vertex_b} >= n7);
  assign sts.n_one     = (nm1 == '0);
  assign sts.u_last    = (u_r == v_r - VW'(1));
  assign sts.found     = found;
  assign sts.v_last    = v_last;
  assign sts.slot_free = !out_valid_r || out_ready;

  // Adjacency port selection.
  always_comb begin
    adj_re    = cmd.row_rd_a || cmd.row_rd_b || cmd.row_rd_v;
    priority if (cmd.row_rd_a) begin
      adj_raddr = a_r;
    end else if (cmd.row_rd_b) begin
      adj_raddr = b_r;
    end else begin
      adj_raddr = v_r;
    end
    adj_we    = cmd.row_wr_a || cmd.row_wr_b;
    adj_waddr = cmd.row_wr_a ? a_r : b_r;
    adj_wdata = row_w | (cmd.row_wr_a ? (VLIM'(1) << b_r) : (VLIM'(1) << a_r));
  end

  // Color port selection.
  always_comb begin
    col_re    = cmd.scan_step || cmd.emit_rd;
    col_raddr = cmd.scan_step ? u_r : v_r;
    col_we    = cmd.run_init || (cmd.find_step && found);
    col_waddr = cmd.run_init ? '0 : v_r;
    col_wdata = cmd.run_init ? '0 : c_r;
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rd_r <= adj_mem[adj_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    if (col_re) begin
      col_rd_r <= col_mem[col_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      rd_vld_r    <= 1'b0;
      vcount_r    <= ggc_pkg::VCOUNT_RESET;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        vcount_r <= cfg_data;
      end
      if (cmd.clear_graph) begin
        row_vld_r <= '0;
      end else if (adj_we) begin
        row_vld_r[adj_waddr] <= 1'b1;
      end
      if (adj_re) begin
        rd_vld_r <= row_vld_r[adj_raddr];
      end
      pend_r <= cmd.scan_step && row_w[u_r];
      if (cmd.out_load_edge || cmd.out_load_color) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      a_r   <= in_data.vertex_a[VW-1:0];
      b_r   <= in_data.vertex_b[VW-1:0];
      rej_r <= sts.reject;
    end

    if (cmd.run_init) begin
      total_r <= (VW+1)'(1);
    end else if (cmd.find_step && found && (c_plus1 > total_r)) begin
      total_r <= c_plus1;
    end

    priority if (cmd.run_init) begin
      v_r <= VW'(1);
    end else if (cmd.emit_start) begin
      v_r <= '0;
    end else if ((cmd.find_step && found) || cmd.out_load_color) begin
      v_r <= v_r + VW'(1);
    end else begin
      v_r <= v_r;
    end

    if (cmd.row_rd_v) begin
      u_r    <= '0;
      c_r    <= '0;
      mask_r <= '0;
    end else begin
      if (cmd.scan_step) begin
        u_r <= u_r + VW'(1);
      end
      if (pend_r) begin
        mask_r[col_rd_r] <= 1'b1;
      end
      if (cmd.find_step && !found) begin
        c_r <= c_r + VW'(1);
      end
    end

    if (cmd.out_load_edge) begin
      out_q_r.vertex        <= 6'd0;
      out_q_r.color         <= 6'd0;
      out_q_r.colors_used   <= 7'd0;
      out_q_r.edge_rejected <= rej_r;
      out_q_r.last          <= 1'b1;
    end else if (cmd.out_load_color) begin
      out_q_r.vertex        <= 6'(v_r);
      out_q_r.color         <= 6'(col_rd_r);
      out_q_r.colors_used   <= v_last ? 7'(total_r) : 7'd0;
      out_q_r.edge_rejected <= 1'b0;
      out_q_r.last          <= v_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

endmodule

/* hdl/greedy_graph_coloring.sv */
// First-fit greedy graph coloring. The graph is loaded one edge at a time into
// an adjacency bit matrix; an add-edge transfer returns one status result
// (edge_rejected set when an endpoint is at or above the vertex count, last
// always set) after reading and rewriting the row of each endpoint in turn,
// steps that a rejected edge skips. A run transfer colors vertices 0 to n-1
// in order, each taking the smallest color that no lower-numbered neighbor
// holds, and then returns one result per vertex, the last carrying colors_used.
// Each vertex needs a walk over the lower-numbered vertices through one color
// memory read port and then a one-bit-per-cycle search for the first free
// color. A clear transfer empties the graph and returns nothing; operation 3
// is ignored. The user is to write the vertex count register through the cfg
// channel only while the block is idle; the block itself does not enforce
// this. A count of zero acts as one and a count above the storage size acts
// as that size.
module greedy_graph_coloring #(
  parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ggc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ggc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  ggc_pkg::ctrl_cmd_t  cmd;
  ggc_pkg::dp_status_t sts;

  // The register is always ready to take a transfer.
  assign cfg_ready = 1'b1;

  // Sequencing of edge loads, the coloring walk and the result stream.
  ggc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Matrix and color memories, counters, used-color mask and output register.
  ggc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* verif/tb_greedy_graph_coloring.sv */
module tb_greedy_graph_coloring;

  // Operation code that the block must ignore without producing a result.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // The random phase stops once this many meaningful operations have been queued.
  localparam int RANDOM_OPS = 380;
  // Idle cycles allowed after the last result before a register write.
  localparam int SETTLE_CYCLES = 16;
  // Idle cycles watched at the very end for stray results.
  localparam int END_CYCLES = 64;
  // A full 64-vertex run computes every color before its first result appears,
  // so the watchdog limit is set well above that quiet stretch.
  localparam int STALL_LIMIT = 40000;
  localparam int MAX_REPORTS = 10;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  ggc_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  ggc_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [6:0]         cfg_data;

  greedy_graph_coloring u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the graph and the coloring state, updated at every accepted
  // transfer so that the expected results follow the exact order of acceptance.
  logic [63:0] adj_rows [ggc_pkg::ROW_LIMIT];
  logic [5:0]  vertex_colors [ggc_pkg::ROW_LIMIT];
  logic [6:0]  colors_in_use;
  logic [6:0]  vertex_count;

  // Operations waiting to be driven, and color or edge status reports that the
  // block still owes us, oldest first.
  ggc_pkg::in_item_t  pending_ops[$];
  ggc_pkg::out_item_t expected_reports[$];

  // Set by the monitor when an input transfer took place at the last rising edge.
  logic in_taken;
  int   quiet_cycles;
  int   mismatch_count;
  int   send_idle_pct;
  int   recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A count of zero behaves as one vertex, and anything above the matrix size
  // is clipped to the matrix size.
  function automatic int active_vertices(input logic [6:0] count);
    if (count == 7'd0) return 1;
    if (count > ggc_pkg::ROW_LIMIT) return ggc_pkg::ROW_LIMIT;
    return count;
  endfunction

  // Applies one accepted operation to the shadow graph and queues the reports
  // that it must produce.
  function automatic void apply_graph_op(input ggc_pkg::in_item_t item);
    int                 n;
    int                 c;
    logic [63:0]        seen;
    ggc_pkg::out_item_t rpt;
    n = active_vertices(vertex_count);
    case (item.operation)
      ggc_pkg::OP_ADD_EDGE: begin
        // Every edge gets exactly one status report; an endpoint outside the
        // active range rejects the whole edge and leaves the matrix alone.
        rpt = '0;
        rpt.last = 1'b1;
        if (item.vertex_a >= n || item.vertex_b >= n) begin
          rpt.edge_rejected = 1'b1;
        end else begin
          adj_rows[item.vertex_a][item.vertex_b] = 1'b1;
          adj_rows[item.vertex_b][item.vertex_a] = 1'b1;
        end
        expected_reports = {expected_reports, rpt};
      end
      ggc_pkg::OP_CLEAR: begin
        // Clearing touches only the matrix; earlier colors stay as they were.
        for (int r = 0; r < ggc_pkg::ROW_LIMIT; r++) begin
          adj_rows[r] = '0;
        end
      end
      ggc_pkg::OP_RUN: begin
        // First-fit coloring in index order. Only lower-numbered neighbors
        // count, so self loops and rows beyond the active range never matter.
        vertex_colors[0] = '0;
        colors_in_use = 7'd1;
        for (int v = 1; v < n; v++) begin
          seen = '0;
          for (int u = 0; u < v; u++) begin
            if (adj_rows[v][u]) seen[vertex_colors[u]] = 1'b1;
          end
          c = 0;
          while (c < 63 && seen[c]) c++;
          vertex_colors[v] = 6'(c);
          if (c + 1 > colors_in_use) colors_in_use = 7'(c + 1);
        end
        for (int v = 0; v < n; v++) begin
          rpt = '0;
          rpt.vertex = 6'(v);
          rpt.color = vertex_colors[v];
          if (v == n - 1) begin
            rpt.colors_used = colors_in_use;
            rpt.last = 1'b1;
          end
          expected_reports = {expected_reports, rpt};
        end
      end
      default: begin
        // The unused code is dropped by the block without a trace.
      end
    endcase
  endfunction

  function automatic void log_mismatch(input string what,
                                       input ggc_pkg::out_item_t want,
                                       input ggc_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch, %s: expected vertex=%0d color=%0d used=%0d rej=%0b last=%0b",
               what, want.vertex, want.color, want.colors_used, want.edge_rejected,
               want.last);
      $display("  actual vertex=%0d color=%0d used=%0d rej=%0b last=%0b",
               got.vertex, got.color, got.colors_used, got.edge_rejected, got.last);
    end
  endfunction

  function automatic void queue_op(input logic [1:0] op, input logic [5:0] a,
                                   input logic [5:0] b);
    ggc_pkg::in_item_t item;
    item.operation = op;
    item.vertex_a = a;
    item.vertex_b = b;
    pending_ops = {pending_ops, item};
  endfunction

  // Monitor: everything is sampled at the rising edge, where the inputs have
  // been stable since the falling edge. Output checks come before the
  // prediction of a newly accepted operation, since a result can never belong
  // to an operation accepted at the same edge.
  always @(posedge clk) begin : monitor
    ggc_pkg::out_item_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      in_taken = in_valid && in_ready;
      if (in_taken || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          log_mismatch("result with nothing outstanding", '0, out_data);
        end else begin
          want = expected_reports.pop_front();
          if (out_data.vertex !== want.vertex || out_data.color !== want.color ||
              out_data.colors_used !== want.colors_used ||
              out_data.edge_rejected !== want.edge_rejected ||
              out_data.last !== want.last) begin
            log_mismatch("wrong result", want, out_data);
          end
        end
      end
      if (cfg_valid && cfg_ready) vertex_count = cfg_data;
      if (in_taken) apply_graph_op(in_data);
    end
  end

  // Driver: a new operation goes out only once the previous one has been
  // transferred, and valid is decided once per falling edge so it never
  // glitches. The receiver stalls independently on every cycle.
  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!in_valid || in_taken) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer on any channel.
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Waits until every queued operation has been transferred and answered, then
  // lets the block finish any silent work such as a clear.
  task automatic drain_and_settle(input int cycles);
    while (pending_ops.size() != 0 || in_valid || expected_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [6:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int          random_ops;
    int          stage;
    int          n;
    int          edge_total;
    int          roll;
    logic [6:0]  count_val;
    logic [5:0]  a;
    logic [5:0]  b;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_taken = 1'b0;
    quiet_cycles = 0;
    mismatch_count = 0;
    send_idle_pct = 25;
    recv_stall_pct = 55;
    for (int r = 0; r < ggc_pkg::ROW_LIMIT; r++) begin
      adj_rows[r] = '0;
      vertex_colors[r] = '0;
    end
    colors_in_use = '0;
    vertex_count = ggc_pkg::VCOUNT_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed checks at the reset count of 64: a triangle needs three colors,
    // a self loop and the extreme vertex numbers, an ignored operation code, and
    // vertex fields that a run or a clear must not look at.
    queue_op(ggc_pkg::OP_ADD_EDGE, 6'd0, 6'd1);
    queue_op(ggc_pkg::OP_ADD_EDGE, 6'd1, 6'd2);
    queue_op(ggc_pkg::OP_ADD_EDGE, 6'd2, 6'd0);
    queue_op(ggc_pkg::OP_ADD_EDGE, 6'd5, 6'd5);
    queue_op(ggc_pkg::OP_ADD_EDGE, 6'd63, 6'd62);
    queue_op(ggc_pkg::OP_ADD_EDGE, 6'd63, 6'd0);
    queue_op(OP_UNUSED, 6'd63, 6'd63);
    queue_op(ggc_pkg::OP_RUN, 6'd63, 6'd63);
    queue_op(ggc_pkg::OP_CLEAR, 6'd42, 6'd21);
    queue_op(ggc_pkg::OP_RUN, 6'd0, 6'd0);
    // These edges become stale once the count shrinks below them.
    queue_op(ggc_pkg::OP_ADD_EDGE, 6'd10, 6'd11);
    queue_op(ggc_pkg::OP_ADD_EDGE, 6'd1, 6'd3);
    drain_and_settle(SETTLE_CYCLES);

    // Four vertices: endpoints at or above the count are rejected.
    write_vertex_count(7'd4);
    queue_op(ggc_pkg::OP_ADD_EDGE, 6'd3, 6'd4);
    queue_op(ggc_pkg::OP_ADD_EDGE, 6'd63, 6'd0);
    queue_op(ggc_pkg::OP_ADD_EDGE, 6'd0, 6'd3);
    queue_op(ggc_pkg::OP_RUN, 6'd17, 6'd9);
    drain_and_settle(SETTLE_CYCLES);

    // A zero count acts as a single vertex.
    write_vertex_count(7'd0);
    queue_op(ggc_pkg::OP_ADD_EDGE, 6'd0, 6'd0);
    queue_op(ggc_pkg::OP_ADD_EDGE, 6'd0, 6'd1);
    queue_op(ggc_pkg::OP_RUN, 6'd0, 6'd0);
    drain_and_settle(SETTLE_CYCLES);

    // The largest register value is clipped to the full matrix, and the stale
    // edges from before come back into play.
    write_vertex_count(7'd127);
    queue_op(ggc_pkg::OP_RUN, 6'd0, 6'd63);
    queue_op(ggc_pkg::OP_CLEAR, 6'd63, 6'd0);

    // Random phase: each round picks a count, usually clears, loads a graph
    // that is mostly well formed and ends with a run. The idle pattern moves
    // from sender-light to receiver-light to no idling at all.
    random_ops = 0;
    while (random_ops < RANDOM_OPS) begin
      drain_and_settle(SETTLE_CYCLES);
      stage = random_ops * 3 / RANDOM_OPS;
      if (stage == 0) begin
        send_idle_pct = 25;
        recv_stall_pct = 55;
      end else if (stage == 1) begin
        send_idle_pct = 55;
        recv_stall_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end

      roll = $urandom_range(19);
      if (roll == 0) count_val = 7'd0;
      else if (roll == 1) count_val = 7'd127;
      else if (roll == 2) count_val = 7'd64;
      else if (roll == 3) count_val = 7'($urandom_range(127, 65));
      else if (roll < 7) count_val = 7'($urandom_range(63, 17));
      else count_val = 7'($urandom_range(16, 1));
      write_vertex_count(count_val);
      n = active_vertices(count_val);

      if ($urandom_range(9) < 7) begin
        queue_op(ggc_pkg::OP_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)));
        random_ops++;
      end

      // Small graphs get many edges so they become dense and need many colors.
      edge_total = $urandom_range(4, (n < 12) ? 3 * n + 4 : 36);
      for (int e = 0; e < edge_total; e++) begin
        roll = $urandom_range(99);
        if (roll < 80) begin
          queue_op(ggc_pkg::OP_ADD_EDGE, 6'($urandom_range(n - 1)),
                   6'($urandom_range(n - 1)));
          random_ops++;
        end else if (roll < 92) begin
          // Push one endpoint to or beyond the count where that is possible.
          a = 6'($urandom_range(63, (n < 64) ? n : 0));
          b = 6'($urandom_range(63));
          if ($urandom_range(1)) queue_op(ggc_pkg::OP_ADD_EDGE, a, b);
          else queue_op(ggc_pkg::OP_ADD_EDGE, b, a);
          random_ops++;
        end else if (roll < 96) begin
          queue_op(OP_UNUSED, 6'($urandom_range(63)), 6'($urandom_range(63)));
        end else begin
          queue_op(ggc_pkg::OP_RUN, 6'($urandom_range(63)), 6'($urandom_range(63)));
          random_ops++;
        end
      end
      queue_op(ggc_pkg::OP_RUN, 6'($urandom_range(63)), 6'($urandom_range(63)));
      random_ops++;
    end

    drain_and_settle(END_CYCLES);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
